/* rtl/core/gf2r_pkg.sv */
// Shared types, constants and helpers of the GF(2) rank unit.
// No dependencies; every other file of the block refers to this package.
package gf2r_pkg;

    localparam int ROW_W        = 32;
    localparam int CFG_W        = 6;
    localparam int RANK_W       = 6;
    localparam int MAX_COLS_DEF = 32;

    localparam logic [CFG_W-1:0] COLS_RESET = 6'd32;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Control of one basis queue for one cycle.
    typedef struct packed {
        logic load;   // replace the contents with the identity prefix
        logic pop;    // drop the head vector, all cells move one place forward
        logic push;   // append the push vector at the tail
    } t_q_ctrl;

    // Control of one cell of a queue.
    typedef struct packed {
        logic load;
        logic shift;
        logic take;
    } t_cell_ctrl;

    // Column count in effect: a register value above the supported maximum acts as it.
    function automatic logic [CFG_W:0] clamp_cols(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W:0]   maxc);
        logic [CFG_W:0] v_ext;
        v_ext = {1'b0, v};
        return (v_ext > maxc) ? maxc : v_ext;
    endfunction

endpackage

/* rtl/core/gf2r_if.sv */
// Valid/ready channel interfaces of the GF(2) rank unit: row input and rank result.
// Depends on gf2r_pkg for the payload widths.
interface gf2r_in_if;
    logic                       valid;
    logic                       ready;
    logic [gf2r_pkg::ROW_W-1:0] row_bits;
    logic                       start_matrix;

    modport source (output valid, output row_bits, output start_matrix, input ready);
    modport sink   (input valid, input row_bits, input start_matrix, output ready);
endinterface

interface gf2r_out_if;
    logic                        valid;
    logic                        ready;
    logic [gf2r_pkg::RANK_W-1:0] rank_so_far;
    logic                        row_independent;

    modport source (output valid, output rank_so_far, output row_independent, input ready);
    modport sink   (input valid, input rank_so_far, input row_independent, output ready);
endinterface

/* rtl/core/gf2_rank_by_null_space_unit.sv */
// Top level of the GF(2) rank unit: sequencer, two basis queues, result register.
// Depends on gf2r_pkg, gf2r_if (channel interfaces) and gf2r_queue.
//
// Usage: rows arrive on i_in, one matrix row per transaction; bit j of row_bits is
// column j. start_matrix restarts the null basis to the identity before the row is
// used. Each row produces one transaction on o_out with the rank of all rows since
// the restart and a flag that tells whether this row raised the rank.
// i_cfg_we/i_cfg_wdata write the column count; a write also restarts the matrix.
// The null basis is kept in order as queue A followed by queue B. A row pops every
// basis vector once, one per cycle through a single parity test at the queue heads:
// even vectors go back to queue A, later odd vectors XORed with the first odd one
// go to queue B. The result is registered once the last basis vector is popped;
// the null dimension is at most MAX_COLS. A new row is accepted only once the
// result is loaded, so the unit takes no new row while one is in progress.
// The result register holds its transaction until the receiver takes it; while it
// is still full, the next row's final cycle waits for it.
// Reset restores a column count of 32 (clamped to MAX_COLS) and the identity basis.
module gf2_rank_by_null_space_unit #(
    parameter int MAX_COLS = gf2r_pkg::MAX_COLS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    gf2r_in_if.sink                    i_in,
    gf2r_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [gf2r_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int SW = CW + 1;
    localparam logic [gf2r_pkg::CFG_W:0] MAXC = (gf2r_pkg::CFG_W + 1)'(MAX_COLS);

    gf2r_pkg::t_state r_state;
    gf2r_pkg::t_state n_state;

    logic [gf2r_pkg::CFG_W-1:0] r_cols;
    logic [MAX_COLS-1:0]        r_row;
    logic [MAX_COLS-1:0]        r_pivot;
    logic                       r_found;
    logic [CW-1:0]              r_rem_a;
    logic [CW-1:0]              r_rem_b;
    logic                       r_out_valid;
    logic [gf2r_pkg::RANK_W-1:0] r_out_rank;
    logic                       r_out_ind;

    logic                in_ready;
    logic                accept;
    logic                finish;
    logic                pop_a;
    logic                pop_b;
    logic                odd;
    logic [CW-1:0]       cols_act;
    logic [MAX_COLS-1:0] row_m;
    logic [MAX_COLS-1:0] head;
    logic [MAX_COLS-1:0] a_head;
    logic [MAX_COLS-1:0] b_head;
    logic [CW-1:0]       a_cnt;
    logic [CW-1:0]       b_cnt;
    logic [CW-1:0]       load_cnt;
    logic [SW-1:0]       dim_sum;
    logic [SW-1:0]       rank_full;

    gf2r_pkg::t_q_ctrl q_a;
    gf2r_pkg::t_q_ctrl q_b;

    assign cols_act = CW'(gf2r_pkg::clamp_cols(r_cols, MAXC));
    assign accept   = i_in.valid && in_ready;

    // Row bits beyond the column count, or beyond the row width, read as zero.
    for (genvar j = 0; j < MAX_COLS; j++) begin : g_row
        if (j < gf2r_pkg::ROW_W) begin : g_in
            assign row_m[j] = i_in.row_bits[j] && (CW'(j) < cols_act);
        end else begin : g_zero
            assign row_m[j] = 1'b0;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gf2r_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = gf2r_pkg::ST_RUN;
                end
            end
            gf2r_pkg::ST_RUN: begin
                if (finish) begin
                    n_state = gf2r_pkg::ST_IDLE;
                end
            end
            default: n_state = gf2r_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        in_ready = 1'b0;
        pop_a    = 1'b0;
        pop_b    = 1'b0;
        finish   = 1'b0;
        case (r_state)
            gf2r_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            gf2r_pkg::ST_RUN: begin
                if (r_rem_a != '0) begin
                    pop_a = 1'b1;
                end else if (r_rem_b != '0) begin
                    pop_b = 1'b1;
                end else begin
                    finish = !r_out_valid || o_out.ready;
                end
            end
            default: ;
        endcase
    end

    assign head = pop_a ? a_head : b_head;
    assign odd  = ^(head & r_row);

    always_comb begin
        q_a.load = !i_rst_n || i_cfg_we || (accept && i_in.start_matrix);
        q_a.pop  = pop_a;
        q_a.push = (pop_a || pop_b) && !odd;
        q_b.load = q_a.load;
        q_b.pop  = pop_b;
        q_b.push = (pop_a || pop_b) && odd && r_found;
    end

    always_comb begin
        if (!i_rst_n) begin
            load_cnt = CW'(gf2r_pkg::clamp_cols(gf2r_pkg::COLS_RESET, MAXC));
        end else if (i_cfg_we) begin
            load_cnt = CW'(gf2r_pkg::clamp_cols(i_cfg_wdata, MAXC));
        end else begin
            load_cnt = cols_act;
        end
    end

    gf2r_queue #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_queue_a (
        .i_clk        (i_clk),
        .i_ctrl       (q_a),
        .i_load_count (load_cnt),
        .i_push_data  (head),
        .o_head       (a_head),
        .o_count      (a_cnt)
    );

    gf2r_queue #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_queue_b (
        .i_clk        (i_clk),
        .i_ctrl       (q_b),
        .i_load_count ('0),
        .i_push_data  (head ^ r_pivot),
        .o_head       (b_head),
        .o_count      (b_cnt)
    );

    assign dim_sum   = SW'(a_cnt) + SW'(b_cnt);
    assign rank_full = SW'(cols_act) - dim_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gf2r_pkg::ST_IDLE;
            r_cols      <= gf2r_pkg::COLS_RESET;
            r_found     <= 1'b0;
            r_rem_a     <= '0;
            r_rem_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cols <= i_cfg_wdata;
            end
            if (accept) begin
                r_found <= 1'b0;
                r_rem_a <= i_in.start_matrix ? cols_act : a_cnt;
                r_rem_b <= i_in.start_matrix ? '0 : b_cnt;
            end else begin
                if (pop_a) begin
                    r_rem_a <= r_rem_a - 1'b1;
                end
                if (pop_b) begin
                    r_rem_b <= r_rem_b - 1'b1;
                end
                if ((pop_a || pop_b) && odd) begin
                    r_found <= 1'b1;
                end
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row <= row_m;
        end
        if ((pop_a || pop_b) && odd && !r_found) begin
            r_pivot <= head;
        end
        if (finish) begin
            r_out_rank <= gf2r_pkg::RANK_W'(rank_full);
            r_out_ind  <= r_found;
        end
    end

    assign i_in.ready            = in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.rank_so_far     = r_out_rank;
    assign o_out.row_independent = r_out_ind;

    // The two queues together never hold more than the whole column space.
    a_dim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SW'(a_cnt) + SW'(b_cnt)) <= SW'(MAX_COLS))
        else $error("null basis larger than the column space");

    // A queue is never popped while empty.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_a |-> (a_cnt != '0)) and (pop_b |-> (b_cnt != '0)))
        else $error("pop from an empty basis queue");

    // An accepted row is always followed by a processing pass.
    a_accept_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == gf2r_pkg::ST_RUN))
        else $error("accepted row not processed");

    // A row that raised the rank leaves a rank of at least one.
    a_ind_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish && r_found |=> (r_out_ind && (r_out_rank != '0)))
        else $error("independent row reported with zero rank");

endmodule

/* rtl/core/gf2r_cell.sv */
// One cell of a basis queue: holds a single null-space vector.
// Depends on gf2r_pkg for the cell control struct.
module gf2r_cell #(
    parameter int W = gf2r_pkg::MAX_COLS_DEF
) (
    input  logic                 i_clk,
    input  gf2r_pkg::t_cell_ctrl i_ctrl,
    input  logic [W-1:0]         i_init,
    input  logic [W-1:0]         i_next,
    input  logic [W-1:0]         i_push,
    output logic [W-1:0]         o_vec
);

    logic [W-1:0] r_vec;
    logic [W-1:0] n_vec;

    always_comb begin
        n_vec = r_vec;
        if (i_ctrl.load) begin
            n_vec = i_init;
        end else if (i_ctrl.take) begin
            n_vec = i_push;
        end else if (i_ctrl.shift) begin
            n_vec = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_vec = r_vec;

endmodule

/* rtl/core/gf2r_queue.sv */
// Basis queue built as a chain of cells: pops at cell 0, appends at the tail.
// Depends on gf2r_pkg and gf2r_cell.
module gf2r_queue #(
    parameter int MAX_COLS = gf2r_pkg::MAX_COLS_DEF,
    parameter int CW       = $clog2(MAX_COLS + 1)
) (
    input  logic                i_clk,
    input  gf2r_pkg::t_q_ctrl   i_ctrl,
    input  logic [CW-1:0]       i_load_count,
    input  logic [MAX_COLS-1:0] i_push_data,
    output logic [MAX_COLS-1:0] o_head,
    output logic [CW-1:0]       o_count
);

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [MAX_COLS-1:0] vec [MAX_COLS];

    always_comb begin
        n_count = r_count;
        if (i_ctrl.load) begin
            n_count = i_load_count;
        end else if (i_ctrl.pop && !i_ctrl.push) begin
            n_count = r_count - 1'b1;
        end else if (i_ctrl.push && !i_ctrl.pop) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
    end

    for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
        gf2r_pkg::t_cell_ctrl cell_ctrl;
        logic [MAX_COLS-1:0]  init;
        logic [MAX_COLS-1:0]  next;

        // Restart contents: entry i holds only column i below the column count.
        assign init = (CW'(i) < i_load_count) ? (MAX_COLS'(1) << i) : '0;

        // When popping, the tail sits one place lower after the move.
        assign cell_ctrl.load  = i_ctrl.load;
        assign cell_ctrl.shift = i_ctrl.pop;
        assign cell_ctrl.take  = i_ctrl.push &&
                                 (i_ctrl.pop ? (CW'(i + 1) == r_count) : (CW'(i) == r_count));

        if (i == MAX_COLS - 1) begin : g_last
            assign next = '0;
        end else begin : g_mid
            assign next = vec[i+1];
        end

        gf2r_cell #(
            .W (MAX_COLS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctrl (cell_ctrl),
            .i_init (init),
            .i_next (next),
            .i_push (i_push_data),
            .o_vec  (vec[i])
        );
    end

    assign o_head  = vec[0];
    assign o_count = r_count;

endmodule
